@@ src/texture_unit_fifo_binder_unit_macros.svh @@
// assertion helpers for the texture unit binder
`ifndef TEXTURE_UNIT_FIFO_BINDER_UNIT_MACROS_SVH
`define TEXTURE_UNIT_FIFO_BINDER_UNIT_MACROS_SVH

`ifndef SYNTH
// property checked at every clock edge outside reset
`define TUFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// condition in one cycle implies a consequence in the next
`define TUFB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TUFB_ASSERT(lbl, prop, msg)
`define TUFB_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ src/tufb_pkg.sv @@
package tufb_pkg;

    // table geometry
    localparam int MAX_UNITS = 16;
    localparam int KEY_BITS  = 32;
    localparam int IDX_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);

    // port field widths
    localparam int UNIT_W     = 5;
    localparam int OUTC_W     = 3;
    localparam int IN_KEY_W   = 32;
    localparam int CFG_W      = 5;
    localparam int DATA_OUT_W = 40;
    localparam int PAD_W      = DATA_OUT_W - UNIT_W - IN_KEY_W;
    localparam int USER_OUT_W = OUTC_W + 1;

    // num_units after reset
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic {
        MODE_BIND   = 1'b0,
        MODE_UNBIND = 1'b1
    } t_mode;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_BIND_HIT    = 3'd0,
        OUTC_BIND_FRESH  = 3'd1,
        OUTC_BIND_EVICT  = 3'd2,
        OUTC_UNBIND_DONE = 3'd3,
        OUTC_UNBIND_MISS = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_number;
        t_outcome            outcome;
        logic [IN_KEY_W-1:0] evicted_key;
        logic                evicted_valid;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] units_used;
        logic [IDX_W-1:0] oldest_unit;
    } t_status;

endpackage

@@ src/tufb_table.sv @@
module tufb_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_update,
    input  tufb_pkg::t_mode                i_mode,
    input  logic [tufb_pkg::IN_KEY_W-1:0]  i_key,
    input  logic [tufb_pkg::CFG_W-1:0]     i_num_units,
    output tufb_pkg::t_result              o_result,
    output tufb_pkg::t_status              o_status
);
    import tufb_pkg::*;

    logic [KEY_BITS-1:0]  r_unit_key [MAX_UNITS];
    logic [MAX_UNITS-1:0] r_mapped;
    logic [MAX_UNITS-1:0] n_mapped;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     n_used;
    logic [IDX_W-1:0]     r_oldest;
    logic [IDX_W-1:0]     n_oldest;

    logic [KEY_BITS-1:0]  key;
    logic [MAX_UNITS-1:0] match;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [CNT_W-1:0]     eff_units;
    logic                 fresh;
    logic [IDX_W-1:0]     alloc_idx;
    logic                 wr_en;

    assign key = KEY_BITS'(i_key);

    // parallel compare against every mapped unit
    always_comb begin
        for (int i = 0; i < MAX_UNITS; i++) begin
            match[i] = r_mapped[i] && (r_unit_key[i] == key);
        end
    end

    // lowest-numbered matching unit wins
    always_comb begin
        hit     = |match;
        hit_idx = '0;
        for (int i = MAX_UNITS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    // clamp unit count to 1..MAX_UNITS
    always_comb begin
        if (i_num_units == '0) begin
            eff_units = CNT_W'(1);
        end else if (int'(i_num_units) > MAX_UNITS) begin
            eff_units = CNT_W'(MAX_UNITS);
        end else begin
            eff_units = CNT_W'(i_num_units);
        end
    end

    assign fresh     = (r_used < eff_units) && (int'(r_used) < MAX_UNITS);
    assign alloc_idx = fresh ? IDX_W'(r_used) : r_oldest;

    // request decision and next table state
    always_comb begin
        n_mapped = r_mapped;
        n_used   = r_used;
        n_oldest = r_oldest;
        wr_en    = 1'b0;
        o_result = '0;
        o_result.outcome = OUTC_BIND_HIT;

        if (i_mode == MODE_UNBIND) begin
            if (hit) begin
                n_mapped[hit_idx]    = 1'b0;
                o_result.unit_number = UNIT_W'(hit_idx) + UNIT_W'(1);
                o_result.outcome     = OUTC_UNBIND_DONE;
            end else begin
                o_result.outcome     = OUTC_UNBIND_MISS;
            end
        end else if (hit) begin
            o_result.unit_number = UNIT_W'(hit_idx) + UNIT_W'(1);
            o_result.outcome     = OUTC_BIND_HIT;
        end else begin
            wr_en                = 1'b1;
            n_mapped[alloc_idx]  = 1'b1;
            o_result.unit_number = UNIT_W'(alloc_idx) + UNIT_W'(1);
            if (fresh) begin
                n_used           = r_used + CNT_W'(1);
                o_result.outcome = OUTC_BIND_FRESH;
            end else begin
                o_result.outcome = OUTC_BIND_EVICT;
                // round robin over the units in use
                if ((CNT_W'(r_oldest) + CNT_W'(1)) >= r_used) begin
                    n_oldest = '0;
                end else begin
                    n_oldest = r_oldest + IDX_W'(1);
                end
                if (r_mapped[alloc_idx]) begin
                    o_result.evicted_valid = 1'b1;
                    o_result.evicted_key   = IN_KEY_W'(r_unit_key[alloc_idx]);
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= '0;
            r_used   <= '0;
            r_oldest <= '0;
        end else if (i_update) begin
            r_mapped <= n_mapped;
            r_used   <= n_used;
            r_oldest <= n_oldest;
        end
    end

    // key store, no reset
    always_ff @(posedge i_clk) begin
        if (i_update && wr_en) begin
            r_unit_key[alloc_idx] <= key;
        end
    end

    assign o_status.units_used  = r_used;
    assign o_status.oldest_unit = r_oldest;

endmodule

@@ src/texture_unit_fifo_binder_unit.sv @@
// flow: an accepted word is held in the input register until its result is captured in the result register
// throughput: one request per cycle while m_axis_tready does not stall the output; the table
//   lookup and update sit between the input register and the result register
// reset: synchronous active low; clears all mappings, the fill count, the round robin
//   pointer and the valids, and sets num_units to 16
`include "texture_unit_fifo_binder_unit_macros.svh"

module texture_unit_fifo_binder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tufb_pkg::CFG_W-1:0]       i_cfg_wdata,   // num_units
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tufb_pkg::IN_KEY_W-1:0]    s_axis_tdata,  // texture_key
    input  logic                             s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tufb_pkg::DATA_OUT_W-1:0]  m_axis_tdata,  // unit_number, evicted_key, pad
    output logic [tufb_pkg::USER_OUT_W-1:0]  m_axis_tuser   // outcome, evicted_valid
);
    import tufb_pkg::*;

    logic [CFG_W-1:0]    r_num_units;
    logic                r_in_valid;
    t_mode               r_in_mode;
    logic [IN_KEY_W-1:0] r_in_key;
    logic                r_out_valid;
    t_result             r_out;

    logic    advance;
    logic    in_take;
    logic    process;
    t_result result;
    t_status st;

    // handshake
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign process       = r_in_valid && advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_units <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_num_units <= i_cfg_wdata;
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= t_mode'(s_axis_tuser);
            r_in_key  <= s_axis_tdata;
        end
    end

    tufb_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (process),
        .i_mode      (r_in_mode),
        .i_key       (r_in_key),
        .i_num_units (r_num_units),
        .o_result    (result),
        .o_status    (st)
    );

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {PAD_W'(0), r_out.evicted_key, r_out.unit_number};
    assign m_axis_tuser  = {r_out.evicted_valid, r_out.outcome};

    // checks
    `TUFB_ASSERT(a_oldest_in_range, (st.units_used == '0 && st.oldest_unit == '0) || (CNT_W'(st.oldest_unit) < st.units_used), "round robin pointer outside units in use")
    `TUFB_ASSERT(a_zero_unit_on_miss, r_out_valid |-> ((r_out.outcome == OUTC_UNBIND_MISS) == (r_out.unit_number == '0)), "unit number zero does not match unbind miss")
    `TUFB_ASSERT(a_evict_flag, (r_out_valid && r_out.evicted_valid) |-> (r_out.outcome == OUTC_BIND_EVICT), "evicted flag set without eviction")
    `TUFB_ASSERT_NEXT(a_input_held, r_in_valid && !advance, r_in_valid && $stable(r_in_key), "stalled input word lost")

endmodule
